/* rtl/core/hbst_pkg.sv */
// ----------------------------------------------------------------------------
// hbst_pkg: shared types and constants for the source tokenizer
// Transfer structs, byte classes, parse phases, result codes and the
// table of reserved header names.
// ----------------------------------------------------------------------------
package hbst_pkg;

  // input transfer
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_source;
  } item_t;

  // result transfer
  typedef struct packed {
    logic [7:0] byte_out;
    logic [3:0] kind;
    logic [3:0] error_code;
    logic       document_done;
  } result_t;

  // character classes found by the front end
  typedef struct packed {
    logic is_blank;
    logic is_break;
    logic is_upper;
    logic is_digit;
    logic is_under;
    logic is_colon;
    logic is_dash;
  } byte_class_t;

  // entry of the queue between front and back
  typedef struct packed {
    item_t       item;
    byte_class_t cls;
  } tok_t;

  // parse phases
  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_KEY    = 3'd1,
    PH_VSTART = 3'd2,
    PH_VALUE  = 3'd3,
    PH_SEP    = 3'd4,
    PH_BSTART = 3'd5,
    PH_BODY   = 3'd6
  } phase_t;

  // byte tags
  typedef enum logic [3:0] {
    KIND_SKIP      = 4'd0,
    KIND_KEY       = 4'd1,
    KIND_KEY_END   = 4'd2,
    KIND_VALUE     = 4'd3,
    KIND_VALUE_END = 4'd4,
    KIND_SEP       = 4'd5,
    KIND_BODY      = 4'd6,
    KIND_BODY_LAST = 4'd7,
    KIND_DISCARD   = 4'd8
  } kind_t;

  // error codes
  typedef enum logic [3:0] {
    ERR_NONE        = 4'd0,
    ERR_NO_KEY_SEP  = 4'd1,
    ERR_BAD_KEY     = 4'd2,
    ERR_FORBIDDEN   = 4'd3,
    ERR_NO_VALUE    = 4'd4,
    ERR_BAD_SEP     = 4'd5,
    ERR_EMPTY       = 4'd6,
    ERR_NO_COLON    = 4'd7,
    ERR_VALUE_END   = 4'd8,
    ERR_NO_LINE_END = 4'd9
  } err_t;

  // character constants
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // reserved header names, right-aligned text, first char at the top
  localparam int unsigned NUM_NAMES = 11;
  localparam int unsigned NAME_BITS = 160;
  localparam logic [4:0]  KEY_LEN_MAX = 5'd31;

  localparam logic [NAME_BITS-1:0] NAME_TEXT [NUM_NAMES] = '{
    "FILENAME", "CONTENT",
    NAME_BITS'({"DATE_", "FORMATTED"}),
    NAME_BITS'({"DATE_FIRST_", "FORMATTED"}),
    NAME_BITS'({"DATE_LAST_", "FORMATTED"}),
    NAME_BITS'({"PAGE_", "FIRST"}),
    NAME_BITS'({"PAGE_", "PREVIOUS"}),
    NAME_BITS'({"PAGE_", "CURRENT"}),
    NAME_BITS'({"PAGE_", "NEXT"}),
    NAME_BITS'({"PAGE_", "LAST"}),
    NAME_BITS'({"BL", "OGC_", "VERSION"})
  };

  localparam logic [4:0] NAME_LEN [NUM_NAMES] = '{
    5'd8, 5'd7, 5'd14, 5'd20, 5'd19, 5'd10, 5'd13, 5'd12, 5'd9, 5'd9, 5'd13
  };

  // true when name idx has character c at position pos
  function automatic logic name_hit(input int unsigned idx, input logic [4:0] pos,
                                    input logic [7:0] c);
    logic [NAME_BITS-1:0] txt;
    logic [4:0]           len;
    logic [7:0]           sh;
    logic [7:0]           ch;
    txt = NAME_TEXT[idx];
    len = NAME_LEN[idx];
    sh  = {3'b000, 5'(len - pos - 5'd1)} << 3;
    ch  = txt[sh +: 8];
    return (pos < len) && (ch == c);
  endfunction

endpackage

/* rtl/core/hbst_front.sv */
// ----------------------------------------------------------------------------
// hbst_front: input side of the tokenizer
// Accepts source bytes, sorts them into character classes and holds them
// in a two-entry queue for the parser.
// ----------------------------------------------------------------------------
module hbst_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  hbst_pkg::item_t     in_data,
  input  logic                deq,
  output logic                q_valid,
  output hbst_pkg::tok_t      q_head
);

  hbst_pkg::tok_t      ent_r [2];
  logic [1:0]          cnt_r;
  logic [1:0]          cnt_nxt;
  logic                wr_ptr_r;
  logic                rd_ptr_r;
  logic                enq;
  hbst_pkg::byte_class_t cls;
  logic [7:0]          c;

  // character classes
  assign c = in_data.data_byte;
  always_comb begin
    cls.is_blank = (c == hbst_pkg::CH_SPACE) || (c == hbst_pkg::CH_TAB);
    cls.is_break = (c == hbst_pkg::CH_LF) || (c == hbst_pkg::CH_CR);
    cls.is_upper = (c >= 8'h41) && (c <= 8'h5A);
    cls.is_digit = (c >= 8'h30) && (c <= 8'h39);
    cls.is_under = (c == hbst_pkg::CH_UNDER);
    cls.is_colon = (c == hbst_pkg::CH_COLON);
    cls.is_dash  = (c == hbst_pkg::CH_DASH);
  end

  // queue control
  assign in_full = (cnt_r == 2'd2);
  assign enq     = in_push && !in_full;
  assign q_valid = (cnt_r != 2'd0);
  assign q_head  = ent_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (enq && !deq) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!enq && deq) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (enq) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (deq) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (enq) begin
      ent_r[wr_ptr_r] <= '{item: in_data, cls: cls};
    end
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("front queue count out of range");
  a_no_deq_empty: assert property (@(posedge clk) disable iff (!rst_n)
    deq |-> q_valid)
    else $error("front queue read while empty");
`endif

endmodule

/* rtl/core/hbst_back.sv */
// ----------------------------------------------------------------------------
// hbst_back: parser side of the tokenizer
// Runs the header/separator/body phase machine, tracks reserved-name
// matches per key byte, and queues tagged results for the consumer.
// ----------------------------------------------------------------------------
module hbst_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  hbst_pkg::tok_t      q_head,
  output logic                deq,
  input  logic                out_pop,
  output logic                out_empty,
  output hbst_pkg::result_t   out_data
);

  hbst_pkg::phase_t    phase_r;
  hbst_pkg::phase_t    phase_nxt;
  logic [4:0]          key_len_r;
  logic [4:0]          key_len_nxt;
  logic [hbst_pkg::NUM_NAMES-1:0] match_r;
  logic [hbst_pkg::NUM_NAMES-1:0] match_nxt;
  logic [hbst_pkg::NUM_NAMES-1:0] hit;
  logic [hbst_pkg::NUM_NAMES-1:0] len_eq;
  logic                stored_r;
  logic                stored_nxt;
  logic                err_seen_r;
  hbst_pkg::err_t      parse_err;
  hbst_pkg::kind_t     kind;
  hbst_pkg::err_t      err_code;
  logic                take;
  logic                last;
  logic                forbidden;
  logic                key_char;
  logic [4:0]          key_pos;
  logic [4:0]          key_len_inc;
  logic [7:0]          c;
  hbst_pkg::byte_class_t cls;
  hbst_pkg::result_t   res;

  hbst_pkg::result_t   oq_r [2];
  logic [1:0]          oq_cnt_r;
  logic [1:0]          oq_cnt_nxt;
  logic                oq_wr_r;
  logic                oq_rd_r;
  logic                pop;

  assign c    = q_head.item.data_byte;
  assign last = q_head.item.end_of_source;
  assign cls  = q_head.cls;

  // take one byte whenever one is queued and the result queue has room
  assign take = q_valid && (oq_cnt_r != 2'd2);
  assign deq  = take;

  // reserved-name compare, one lane per name
  assign key_pos = (phase_r == hbst_pkg::PH_START) ? 5'd0 : key_len_r;
  always_comb begin
    for (int i = 0; i < hbst_pkg::NUM_NAMES; i++) begin
      hit[i]    = hbst_pkg::name_hit(i, key_pos, c);
      len_eq[i] = (key_len_r == hbst_pkg::NAME_LEN[i]);
    end
  end
  assign forbidden   = |(match_r & len_eq);
  assign key_char    = cls.is_upper || cls.is_digit || cls.is_under;
  assign key_len_inc = (key_len_r == hbst_pkg::KEY_LEN_MAX) ? key_len_r
                                                            : key_len_r + 5'd1;

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    key_len_nxt = key_len_r;
    match_nxt   = match_r;
    stored_nxt  = stored_r;
    parse_err   = hbst_pkg::ERR_NONE;
    unique case (phase_r)
      hbst_pkg::PH_START: begin
        if (cls.is_blank || cls.is_break) begin
          phase_nxt = phase_r;
        end else if (cls.is_upper) begin
          key_len_nxt = 5'd1;
          match_nxt   = hit;
          phase_nxt   = hbst_pkg::PH_KEY;
        end else if (cls.is_dash) begin
          phase_nxt = hbst_pkg::PH_SEP;
        end else begin
          parse_err = hbst_pkg::ERR_NO_KEY_SEP;
        end
      end
      hbst_pkg::PH_KEY: begin
        if (key_char) begin
          key_len_nxt = key_len_inc;
          match_nxt   = match_r & hit;
        end else if (cls.is_colon) begin
          if (forbidden) begin
            parse_err = hbst_pkg::ERR_FORBIDDEN;
          end else begin
            phase_nxt = hbst_pkg::PH_VSTART;
          end
        end else begin
          parse_err = hbst_pkg::ERR_BAD_KEY;
        end
      end
      hbst_pkg::PH_VSTART: begin
        if (cls.is_break) begin
          parse_err = hbst_pkg::ERR_NO_VALUE;
        end else begin
          phase_nxt = hbst_pkg::PH_VALUE;
        end
      end
      hbst_pkg::PH_VALUE: begin
        if (cls.is_break) begin
          stored_nxt = 1'b1;
          phase_nxt  = hbst_pkg::PH_START;
        end
      end
      hbst_pkg::PH_SEP: begin
        if (cls.is_break) begin
          phase_nxt = hbst_pkg::PH_BSTART;
        end else if (!cls.is_dash) begin
          parse_err = hbst_pkg::ERR_BAD_SEP;
        end
      end
      hbst_pkg::PH_BSTART: begin
        if (!cls.is_break) begin
          phase_nxt = hbst_pkg::PH_BODY;
        end
      end
      default: begin
        if (last) begin
          stored_nxt = 1'b1;
        end
      end
    endcase
  end

  // result tag and error code
  always_comb begin
    kind     = hbst_pkg::KIND_DISCARD;
    err_code = hbst_pkg::ERR_NONE;
    unique case (phase_r)
      hbst_pkg::PH_START: begin
        if (cls.is_blank || cls.is_break) begin
          kind = hbst_pkg::KIND_SKIP;
        end else if (cls.is_upper) begin
          kind = hbst_pkg::KIND_KEY;
        end else if (cls.is_dash) begin
          kind = hbst_pkg::KIND_SEP;
        end
      end
      hbst_pkg::PH_KEY: begin
        if (key_char) begin
          kind = hbst_pkg::KIND_KEY;
        end else if (cls.is_colon) begin
          kind = hbst_pkg::KIND_KEY_END;
        end
      end
      hbst_pkg::PH_VSTART: kind = hbst_pkg::KIND_VALUE;
      hbst_pkg::PH_VALUE: begin
        kind = cls.is_break ? hbst_pkg::KIND_VALUE_END : hbst_pkg::KIND_VALUE;
      end
      hbst_pkg::PH_SEP:    kind = hbst_pkg::KIND_SEP;
      hbst_pkg::PH_BSTART: begin
        kind = cls.is_break ? hbst_pkg::KIND_SKIP : hbst_pkg::KIND_BODY;
      end
      default: begin
        kind = last ? hbst_pkg::KIND_BODY_LAST : hbst_pkg::KIND_BODY;
      end
    endcase
    if (parse_err != hbst_pkg::ERR_NONE) begin
      kind     = hbst_pkg::KIND_DISCARD;
      err_code = parse_err;
    end else if (last && !stored_nxt) begin
      // end-of-source errors depend on where the byte left the parse
      unique case (phase_nxt)
        hbst_pkg::PH_START:  err_code = hbst_pkg::ERR_EMPTY;
        hbst_pkg::PH_KEY:    err_code = hbst_pkg::ERR_NO_COLON;
        hbst_pkg::PH_VSTART: err_code = hbst_pkg::ERR_VALUE_END;
        hbst_pkg::PH_VALUE:  err_code = hbst_pkg::ERR_NO_LINE_END;
        default:             err_code = hbst_pkg::ERR_NONE;
      endcase
    end
    if (err_seen_r) begin
      kind     = hbst_pkg::KIND_DISCARD;
      err_code = hbst_pkg::ERR_NONE;
    end
  end

  // parser state, back to reset after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n || (take && last)) begin
      phase_r    <= hbst_pkg::PH_START;
      key_len_r  <= 5'd0;
      match_r    <= '1;
      stored_r   <= 1'b0;
      err_seen_r <= 1'b0;
    end else if (take && !err_seen_r) begin
      phase_r    <= phase_nxt;
      key_len_r  <= key_len_nxt;
      match_r    <= match_nxt;
      stored_r   <= stored_nxt;
      err_seen_r <= (parse_err != hbst_pkg::ERR_NONE);
    end
  end

  // result queue
  assign res.byte_out      = c;
  assign res.kind          = kind;
  assign res.error_code    = err_code;
  assign res.document_done = last;

  assign out_empty = (oq_cnt_r == 2'd0);
  assign out_data  = oq_r[oq_rd_r];
  assign pop       = out_pop && !out_empty;

  always_comb begin
    oq_cnt_nxt = oq_cnt_r;
    if (take && !pop) begin
      oq_cnt_nxt = oq_cnt_r + 2'd1;
    end else if (!take && pop) begin
      oq_cnt_nxt = oq_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_cnt_r <= 2'd0;
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
    end else begin
      oq_cnt_r <= oq_cnt_nxt;
      if (take) begin
        oq_wr_r <= !oq_wr_r;
      end
      if (pop) begin
        oq_rd_r <= !oq_rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      oq_r[oq_wr_r] <= res;
    end
  end

`ifndef ASSERT_OFF
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    take && last |=> phase_r == hbst_pkg::PH_START && !err_seen_r && !stored_r)
    else $error("parser not back at header start after last byte");
  a_discard_after_err: assert property (@(posedge clk) disable iff (!rst_n)
    take && err_seen_r |-> kind == hbst_pkg::KIND_DISCARD
                           && err_code == hbst_pkg::ERR_NONE)
    else $error("byte after error not discarded quietly");
  a_oq_range: assert property (@(posedge clk) disable iff (!rst_n)
    oq_cnt_r != 2'd3)
    else $error("result queue count out of range");
`endif

endmodule

/* rtl/core/header_and_body_source_tokenizer.sv */
// Path: an accepted byte is registered in the input queue, then the result queue.
// Throughput: one byte per cycle, sustained while the consumer pops every cycle;
// the phase machine and the eleven-lane name compare are combinational in between.
// Reset: synchronous, active low; empties both two-entry queues and returns
// the parser to header start. No clearing pass is needed.
// ----------------------------------------------------------------------------
// header_and_body_source_tokenizer: top level
// Byte classifier and input queue in front, phase machine and result queue
// behind; each side stalls independently.
// ----------------------------------------------------------------------------
module header_and_body_source_tokenizer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  hbst_pkg::item_t   in_data,
  input  logic              out_pop,
  output logic              out_empty,
  output hbst_pkg::result_t out_data
);

  logic           deq;
  logic           q_valid;
  hbst_pkg::tok_t q_head;

  // classifier and input queue
  hbst_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .deq     (deq),
    .q_valid (q_valid),
    .q_head  (q_head)
  );

  // parser and result queue
  hbst_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .deq       (deq),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule
